// ----- sv/csdc_pkg.sv -----
// Shared types and constants for the C source delimiter checker.
package csdc_pkg;

    localparam int DEPTH_BITS_DEF = 16;
    localparam int LINE_BITS_DEF  = 24;
    localparam int REP_LINE_W     = 24;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [6:0] {
        MODE_CODE      = 7'b0000001,
        MODE_STRING    = 7'b0000010,
        MODE_COMMENT   = 7'b0000100,
        MODE_STAR      = 7'b0001000,
        MODE_LIT_OPEN  = 7'b0010000,
        MODE_LIT_ESC   = 7'b0100000,
        MODE_LIT_CLOSE = 7'b1000000
    } mode_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_ESCAPE = 2'd1,
        ERR_APOS   = 2'd2
    } err_t;

    // scanner control state
    typedef struct packed {
        mode_t mode;
        logic  slash;
        err_t  err;
    } ctl_t;

    // one result item
    typedef struct packed {
        logic                  char_valid;
        logic [7:0]            out_char;
        logic                  last_of_run;
        logic [REP_LINE_W-1:0] line_number;
        logic [1:0]            error_code;
        logic                  brace_unbalanced;
        logic                  bracket_unbalanced;
        logic                  paren_unbalanced;
        logic                  report_done;
    } res_t;

endpackage

// ----- sv/csdc_scan.sv -----
// Combinational scanner: next state and up to two results for one input byte.
module csdc_scan
    import csdc_pkg::*;
#(
    parameter int DEPTH_BITS = DEPTH_BITS_DEF,
    parameter int LINE_BITS  = LINE_BITS_DEF
)
(
    input  ctl_t                         ctl,
    input  logic signed [DEPTH_BITS-1:0] brace,
    input  logic signed [DEPTH_BITS-1:0] bracket,
    input  logic signed [DEPTH_BITS-1:0] paren,
    input  logic [LINE_BITS-1:0]         line,
    input  logic [7:0]                   text_byte,
    input  logic                         end_of_text,
    output ctl_t                         ctl_next,
    output logic signed [DEPTH_BITS-1:0] brace_next,
    output logic signed [DEPTH_BITS-1:0] bracket_next,
    output logic signed [DEPTH_BITS-1:0] paren_next,
    output logic [LINE_BITS-1:0]         line_next,
    output res_t                         res0,
    output res_t                         res1,
    output logic [1:0]                   res_cnt
);

    localparam logic signed [DEPTH_BITS-1:0] DMAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic signed [DEPTH_BITS-1:0] DMIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
    localparam logic [LINE_BITS-1:0]         LMAX = {LINE_BITS{1'b1}};

    function automatic logic [REP_LINE_W-1:0] line_rep(input logic [LINE_BITS-1:0] l);
        logic [LINE_BITS+REP_LINE_W-1:0] w;
        w = (LINE_BITS+REP_LINE_W)'(l);
        return w[REP_LINE_W-1:0];
    endfunction

    function automatic res_t char_res(input logic [7:0] ch,
                                      input logic [LINE_BITS-1:0] l,
                                      input err_t e);
        res_t r;
        r             = '0;
        r.char_valid  = 1'b1;
        r.out_char    = ch;
        r.line_number = line_rep(l);
        r.error_code  = e;
        return r;
    endfunction

    logic                 slash_first;
    logic [LINE_BITS-1:0] line_inc;
    err_t                 end_err;
    res_t                 report;

    assign line_inc = (line != LMAX) ? line + 1'b1 : line;

    always_comb
    begin
        end_err = ctl.err;
        if (ctl.err == ERR_NONE)
        begin
            if (ctl.mode == MODE_LIT_ESC)
                end_err = ERR_ESCAPE;
            else if (ctl.mode == MODE_LIT_OPEN || ctl.mode == MODE_LIT_CLOSE)
                end_err = ERR_APOS;
        end
        report                    = '0;
        report.line_number        = line_rep(line);
        report.error_code         = end_err;
        report.brace_unbalanced   = (brace != '0);
        report.bracket_unbalanced = (bracket != '0);
        report.paren_unbalanced   = (paren != '0);
        report.report_done        = 1'b1;
    end

    always_comb
    begin
        ctl_next     = ctl;
        brace_next   = brace;
        bracket_next = bracket;
        paren_next   = paren;
        line_next    = line;
        res0         = '0;
        res1         = '0;
        res_cnt      = 2'd0;
        slash_first  = 1'b0;

        if (end_of_text)
        begin
            if (end_err == ERR_NONE && ctl.slash)
            begin
                res0    = char_res(CH_SLASH, line, ERR_NONE);
                res1    = report;
                res_cnt = 2'd2;
            end
            else
            begin
                res0    = report;
                res_cnt = 2'd1;
            end
            ctl_next.mode  = MODE_CODE;
            ctl_next.slash = 1'b0;
            ctl_next.err   = ERR_NONE;
            brace_next     = '0;
            bracket_next   = '0;
            paren_next     = '0;
            line_next      = LINE_BITS'(1);
        end
        else if (ctl.err == ERR_NONE)
        begin
            case (ctl.mode)
                MODE_STRING:
                    if (text_byte == CH_DQUOTE)
                        ctl_next.mode = MODE_CODE;
                MODE_COMMENT:
                    if (text_byte == CH_STAR)
                        ctl_next.mode = MODE_STAR;
                MODE_STAR:
                    if (text_byte == CH_SLASH)
                        ctl_next.mode = MODE_CODE;
                    else if (text_byte != CH_STAR)
                        ctl_next.mode = MODE_COMMENT;
                MODE_LIT_OPEN:
                    ctl_next.mode = (text_byte == CH_BSLASH) ? MODE_LIT_ESC : MODE_LIT_CLOSE;
                MODE_LIT_ESC:
                    if (text_byte == CH_T || text_byte == CH_BSLASH ||
                        text_byte == CH_A || text_byte == CH_N)
                        ctl_next.mode = MODE_LIT_CLOSE;
                    else
                    begin
                        ctl_next.err  = ERR_ESCAPE;
                        ctl_next.mode = MODE_CODE;
                    end
                MODE_LIT_CLOSE:
                begin
                    if (text_byte != CH_APOS)
                        ctl_next.err = ERR_APOS;
                    ctl_next.mode = MODE_CODE;
                end
                default:
                begin
                    // code mode, and any stray code
                    ctl_next.mode = MODE_CODE;
                    if (text_byte == CH_SLASH)
                    begin
                        if (ctl.slash)
                        begin
                            res0    = char_res(CH_SLASH, line, ERR_NONE);
                            res_cnt = 2'd1;
                        end
                        ctl_next.slash = 1'b1;
                    end
                    else if (text_byte == CH_STAR)
                    begin
                        if (ctl.slash)
                            ctl_next.mode = MODE_COMMENT;
                        else
                        begin
                            res0    = char_res(CH_STAR, line, ERR_NONE);
                            res_cnt = 2'd1;
                        end
                        ctl_next.slash = 1'b0;
                    end
                    else
                    begin
                        // held slash goes out first
                        ctl_next.slash = 1'b0;
                        slash_first    = ctl.slash;
                        if (ctl.slash)
                        begin
                            res0    = char_res(CH_SLASH, line, ERR_NONE);
                            res_cnt = 2'd1;
                        end
                        case (text_byte)
                            CH_NL:
                            begin
                                line_next = line_inc;
                                if (slash_first)
                                begin
                                    res1    = char_res(CH_NL, line_inc, ERR_NONE);
                                    res_cnt = 2'd2;
                                end
                                else
                                begin
                                    res0    = char_res(CH_NL, line_inc, ERR_NONE);
                                    res_cnt = 2'd1;
                                end
                            end
                            CH_APOS:   ctl_next.mode = MODE_LIT_OPEN;
                            CH_DQUOTE: ctl_next.mode = MODE_STRING;
                            CH_LBRACE:
                                if (brace != DMAX) brace_next = brace + 1'b1;
                            CH_RBRACE:
                                if (brace != DMIN) brace_next = brace - 1'b1;
                            CH_LBRACK:
                                if (bracket != DMAX) bracket_next = bracket + 1'b1;
                            CH_RBRACK:
                                if (bracket != DMIN) bracket_next = bracket - 1'b1;
                            CH_LPAREN:
                                if (paren != DMAX) paren_next = paren + 1'b1;
                            CH_RPAREN:
                                if (paren != DMIN) paren_next = paren - 1'b1;
                            default:
                                if (slash_first)
                                begin
                                    res1    = char_res(text_byte, line, ERR_NONE);
                                    res_cnt = 2'd2;
                                end
                                else
                                begin
                                    res0    = char_res(text_byte, line, ERR_NONE);
                                    res_cnt = 2'd1;
                                end
                        endcase
                    end
                end
            endcase
        end

        if (res_cnt == 2'd1)
            res0.last_of_run = 1'b1;
        else if (res_cnt == 2'd2)
            res1.last_of_run = 1'b1;
    end

endmodule

// ----- sv/csdc_outbuf.sv -----
// Two-entry result buffer that drains one result per transfer.
module csdc_outbuf
    import csdc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  logic [1:0] load_cnt,
    input  res_t       load_res0,
    input  res_t       load_res1,
    output logic       free,
    output logic       out_valid,
    input  logic       out_ready,
    output res_t       out_res
);

    logic [1:0] cnt_reg, cnt_next;
    res_t       slot0_reg, slot0_next;
    res_t       slot1_reg, slot1_next;
    logic       out_fire;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_fire  = out_valid & out_ready;
    assign free      = (cnt_reg == 2'd0) | ((cnt_reg == 2'd1) & out_ready);
    assign out_res   = slot0_reg;

    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (load)
        begin
            cnt_next   = load_cnt;
            slot0_next = load_res0;
            slot1_next = load_res1;
        end
        else if (out_fire)
        begin
            if (cnt_reg == 2'd2)
            begin
                slot0_next = slot1_reg;
                cnt_next   = 2'd1;
            end
            else
                cnt_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

// ----- sv/c_source_delimiter_checker.sv -----
// Top level of the C source delimiter checker: input register, scan state, result buffer.
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+-------------------------------------------
//   s_        | s_tvalid / s_tready       | s_tdata[7:0] text_byte, s_tlast end_of_text
//   m_        | m_tvalid / m_tready       | m_tdata, m_tuser, m_tlast last_of_run
//
// One byte per cycle while the result buffer has room for its results: the byte sits in the
// input register, the scanner updates mode, depths and line count combinationally and writes
// up to two results into the result buffer, which passes them to the output. Bytes that make
// two results need two output transfers, and a later byte with results waits until one is taken.
// Reset puts the scanner in code mode, line 1, depths zero, buffers empty.
// A stalled output holds the buffer; silent bytes still advance while it waits.
module c_source_delimiter_checker
    import csdc_pkg::*;
#(
    parameter int DEPTH_BITS = DEPTH_BITS_DEF,
    parameter int LINE_BITS  = LINE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] out_char, [31:8] line_number, [33:32] error_code,
                                   // [34] brace_unbalanced, [35] bracket_unbalanced,
                                   // [36] paren_unbalanced, [39:37] zero
    output logic [1:0]  m_tuser,   // [0] char_valid, [1] report_done
    output logic        m_tlast    // last_of_run
);

    logic                         in_valid_reg, in_valid_next;
    logic [7:0]                   byte_reg;
    logic                         eot_reg;

    ctl_t                         ctl_reg, ctl_next;
    logic signed [DEPTH_BITS-1:0] brace_reg, brace_next;
    logic signed [DEPTH_BITS-1:0] bracket_reg, bracket_next;
    logic signed [DEPTH_BITS-1:0] paren_reg, paren_next;
    logic [LINE_BITS-1:0]         line_reg, line_next;

    res_t                         res0, res1, out_res;
    logic [1:0]                   res_cnt;
    logic                         buf_free;
    logic                         proc_fire;
    logic                         load;

    csdc_scan #(
        .DEPTH_BITS (DEPTH_BITS),
        .LINE_BITS  (LINE_BITS)
    ) u_scan (
        .ctl          (ctl_reg),
        .brace        (brace_reg),
        .bracket      (bracket_reg),
        .paren        (paren_reg),
        .line         (line_reg),
        .text_byte    (byte_reg),
        .end_of_text  (eot_reg),
        .ctl_next     (ctl_next),
        .brace_next   (brace_next),
        .bracket_next (bracket_next),
        .paren_next   (paren_next),
        .line_next    (line_next),
        .res0         (res0),
        .res1         (res1),
        .res_cnt      (res_cnt)
    );

    // silent bytes need no buffer space
    assign proc_fire     = in_valid_reg & (buf_free | (res_cnt == 2'd0));
    assign load          = proc_fire & (res_cnt != 2'd0);
    assign s_tready      = ~in_valid_reg | proc_fire;
    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;

    csdc_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .load_cnt  (res_cnt),
        .load_res0 (res0),
        .load_res1 (res1),
        .free      (buf_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {3'b000,
                      out_res.paren_unbalanced,
                      out_res.bracket_unbalanced,
                      out_res.brace_unbalanced,
                      out_res.error_code,
                      out_res.line_number,
                      out_res.out_char};
    assign m_tuser = {out_res.report_done, out_res.char_valid};
    assign m_tlast = out_res.last_of_run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            ctl_reg.mode  <= MODE_CODE;
            ctl_reg.slash <= 1'b0;
            ctl_reg.err   <= ERR_NONE;
            brace_reg     <= '0;
            bracket_reg   <= '0;
            paren_reg     <= '0;
            line_reg      <= LINE_BITS'(1);
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (proc_fire)
            begin
                ctl_reg     <= ctl_next;
                brace_reg   <= brace_next;
                bracket_reg <= bracket_next;
                paren_reg   <= paren_next;
                line_reg    <= line_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg <= s_tdata;
            eot_reg  <= s_tlast;
        end
    end

endmodule

// ----- tb/sv/csdc_stream_checker.sv -----
// Scoreboard for the C source delimiter checker: predicts each result and checks the output stream.
`timescale 1ns / 1ps

module csdc_stream_checker
    import csdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_text
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // [7:0] out_char, [31:8] line_number, [33:32] error_code,
                                   // [34] brace_unbalanced, [35] bracket_unbalanced,
                                   // [36] paren_unbalanced, [39:37] zero
    input  logic [1:0]  m_tuser,   // [0] char_valid, [1] report_done
    input  logic        m_tlast,   // last_of_run
    output int          fail_count,
    output int          results_due
);

    localparam int DB = DEPTH_BITS_DEF;
    localparam int LB = LINE_BITS_DEF;

    localparam logic signed [DB-1:0] DEPTH_HI = {1'b0, {(DB-1){1'b1}}};
    localparam logic signed [DB-1:0] DEPTH_LO = {1'b1, {(DB-1){1'b0}}};
    localparam logic [LB-1:0]        LINE_TOP = {LB{1'b1}};

    // scanner model state
    mode_t                scan;
    logic                 slash_held;
    err_t                 err_now;
    logic signed [DB-1:0] braces;
    logic signed [DB-1:0] brackets;
    logic signed [DB-1:0] parens;
    logic [LB-1:0]        line_no;

    res_t scan_results [$];
    res_t step_buf [2];
    int   step_n;

    initial
    begin
        fail_count  = 0;
        results_due = 0;
    end

    task automatic clear_scan();
        scan       = MODE_CODE;
        slash_held = 1'b0;
        err_now    = ERR_NONE;
        braces     = '0;
        brackets   = '0;
        parens     = '0;
        line_no    = LB'(1);
    endtask

    function automatic logic signed [DB-1:0] depth_inc(input logic signed [DB-1:0] d);
        return (d == DEPTH_HI) ? d : d + 1'b1;
    endfunction

    function automatic logic signed [DB-1:0] depth_dec(input logic signed [DB-1:0] d);
        return (d == DEPTH_LO) ? d : d - 1'b1;
    endfunction

    task automatic add_result(input logic valid, input logic [7:0] ch, input logic report);
        res_t r;
        r.char_valid         = valid;
        r.out_char           = ch;
        r.last_of_run        = 1'b0;
        r.line_number        = line_no[REP_LINE_W-1:0];
        r.error_code         = err_now;
        r.brace_unbalanced   = report && (braces != 0);
        r.bracket_unbalanced = report && (brackets != 0);
        r.paren_unbalanced   = report && (parens != 0);
        r.report_done        = report;
        step_buf[step_n]     = r;
        step_n++;
    endtask

    task automatic scan_code_byte(input logic [7:0] c);
        if (c == CH_SLASH)
        begin
            if (slash_held)
                add_result(1'b1, CH_SLASH, 1'b0);
            slash_held = 1'b1;
        end
        else if (c == CH_STAR)
        begin
            if (slash_held)
                scan = MODE_COMMENT;
            else
                add_result(1'b1, CH_STAR, 1'b0);
            slash_held = 1'b0;
        end
        else
        begin
            if (slash_held)
                add_result(1'b1, CH_SLASH, 1'b0);
            slash_held = 1'b0;
            case (c)
                CH_NL:
                begin
                    if (line_no != LINE_TOP)
                        line_no = line_no + 1'b1;
                    add_result(1'b1, c, 1'b0);
                end
                CH_APOS:   scan = MODE_LIT_OPEN;
                CH_DQUOTE: scan = MODE_STRING;
                CH_LBRACE: braces = depth_inc(braces);
                CH_RBRACE: braces = depth_dec(braces);
                CH_LBRACK: brackets = depth_inc(brackets);
                CH_RBRACK: brackets = depth_dec(brackets);
                CH_LPAREN: parens = depth_inc(parens);
                CH_RPAREN: parens = depth_dec(parens);
                default:   add_result(1'b1, c, 1'b0);
            endcase
        end
    endtask

    // one accepted input transfer: update the model and queue what it emits
    task automatic scan_byte(input logic [7:0] c, input logic eot);
        res_t r;
        step_n = 0;
        if (eot)
        begin
            if (err_now == ERR_NONE)
            begin
                if (scan == MODE_LIT_ESC)
                    err_now = ERR_ESCAPE;
                else if (scan == MODE_LIT_OPEN || scan == MODE_LIT_CLOSE)
                    err_now = ERR_APOS;
            end
            if (err_now == ERR_NONE && slash_held)
                add_result(1'b1, CH_SLASH, 1'b0);
            add_result(1'b0, 8'h00, 1'b1);
            clear_scan();
        end
        else if (err_now == ERR_NONE)
        begin
            case (scan)
                MODE_STRING:
                    if (c == CH_DQUOTE)
                        scan = MODE_CODE;
                MODE_COMMENT:
                    if (c == CH_STAR)
                        scan = MODE_STAR;
                MODE_STAR:
                    if (c == CH_SLASH)
                        scan = MODE_CODE;
                    else if (c != CH_STAR)
                        scan = MODE_COMMENT;
                MODE_LIT_OPEN:
                    scan = (c == CH_BSLASH) ? MODE_LIT_ESC : MODE_LIT_CLOSE;
                MODE_LIT_ESC:
                    if (c == CH_T || c == CH_BSLASH || c == CH_A || c == CH_N)
                        scan = MODE_LIT_CLOSE;
                    else
                    begin
                        err_now = ERR_ESCAPE;
                        scan    = MODE_CODE;
                    end
                MODE_LIT_CLOSE:
                begin
                    if (c != CH_APOS)
                        err_now = ERR_APOS;
                    scan = MODE_CODE;
                end
                default:
                begin
                    scan = MODE_CODE;
                    scan_code_byte(c);
                end
            endcase
        end
        for (int i = 0; i < step_n; i++)
        begin
            r = step_buf[i];
            r.last_of_run = (i == step_n - 1);
            scan_results.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [23:0] want, input logic [23:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        res_t want;
        if (!rst_n)
        begin
            clear_scan();
            scan_results.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (scan_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual tdata 0x%0h tuser %b",
                             $time, m_tdata, m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = scan_results.pop_front();
                    check_field("char_valid", 24'(want.char_valid), 24'(m_tuser[0]));
                    check_field("out_char", 24'(want.out_char), 24'(m_tdata[7:0]));
                    check_field("last_of_run", 24'(want.last_of_run), 24'(m_tlast));
                    check_field("line_number", want.line_number, m_tdata[31:8]);
                    check_field("error_code", 24'(want.error_code), 24'(m_tdata[33:32]));
                    check_field("brace_unbalanced", 24'(want.brace_unbalanced),
                                24'(m_tdata[34]));
                    check_field("bracket_unbalanced", 24'(want.bracket_unbalanced),
                                24'(m_tdata[35]));
                    check_field("paren_unbalanced", 24'(want.paren_unbalanced),
                                24'(m_tdata[36]));
                    check_field("report_done", 24'(want.report_done), 24'(m_tuser[1]));
                end
            end
            if (s_tvalid && s_tready)
                scan_byte(s_tdata, s_tlast);
        end
        results_due = scan_results.size();
    end

endmodule

// ----- tb/sv/tb_c_source_delimiter_checker.sv -----
// Top of the C source delimiter checker testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_c_source_delimiter_checker;
    import csdc_pkg::*;

    localparam int RANDOM_ITEMS = 1600;
    localparam int CALM_FROM    = 1350;
    localparam int CYCLE_LIMIT  = 1200000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int   fail_count;
    int   results_due;
    int   items_sent = 0;
    int   stall_left = 0;
    logic calm       = 1'b0;

    always #2 clk = ~clk;

    c_source_delimiter_checker u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    csdc_stream_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    // output backpressure in random bursts, none while calm
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (!calm && $urandom_range(4) == 0)
        begin
            stall_left <= $urandom_range(1, 7) - 1;
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(input logic [7:0] b, input logic eot);
        int gap;
        if (!calm && $urandom_range(3) == 0)
        begin
            gap = $urandom_range(1, 7);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        @(posedge clk);
        while (!(s_tvalid && s_tready))
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    task automatic send_end();
        send_item(8'($urandom_range(255)), 1'b1);
    endtask

    function automatic logic [7:0] comment_fill();
        case ($urandom_range(5))
            0:       return CH_STAR;
            1:       return CH_SLASH;
            2:       return CH_NL;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] escape_letter();
        case ($urandom_range(3))
            0:       return CH_T;
            1:       return CH_BSLASH;
            2:       return CH_A;
            default: return CH_N;
        endcase
    endfunction

    // one lexical piece of random C-like text
    task automatic send_token();
        int          roll;
        int          k;
        logic [7:0]  b;
        roll = $urandom_range(99);
        if (roll < 20)
        begin
            b = $urandom_range(1) ? 8'($urandom_range(8'h61, 8'h7A)) : 8'($urandom_range(255));
            send_item(b, 1'b0);
        end
        else if (roll < 35)
        begin
            case ($urandom_range(5))
                0:       b = CH_LBRACE;
                1:       b = CH_RBRACE;
                2:       b = CH_LBRACK;
                3:       b = CH_RBRACK;
                4:       b = CH_LPAREN;
                default: b = CH_RPAREN;
            endcase
            send_item(b, 1'b0);
        end
        else if (roll < 43)
            send_item(CH_NL, 1'b0);
        else if (roll < 55)
        begin
            send_item(CH_SLASH, 1'b0);
            send_item(CH_STAR, 1'b0);
            k = $urandom_range(6);
            repeat (k) send_item(comment_fill(), 1'b0);
            // occasionally left open to the end of the text
            if ($urandom_range(9) != 0)
            begin
                k = $urandom_range(1, 3);
                repeat (k) send_item(CH_STAR, 1'b0);
                send_item(CH_SLASH, 1'b0);
            end
        end
        else if (roll < 65)
        begin
            send_item(CH_DQUOTE, 1'b0);
            k = $urandom_range(6);
            repeat (k)
            begin
                do
                    b = 8'($urandom_range(255));
                while (b == CH_DQUOTE);
                send_item(b, 1'b0);
            end
            send_item(CH_DQUOTE, 1'b0);
        end
        else if (roll < 77)
        begin
            send_item(CH_APOS, 1'b0);
            if ($urandom_range(9) < 7)
            begin
                do
                    b = 8'($urandom_range(255));
                while (b == CH_BSLASH);
                send_item(b, 1'b0);
            end
            else
            begin
                send_item(CH_BSLASH, 1'b0);
                send_item(escape_letter(), 1'b0);
            end
            send_item(CH_APOS, 1'b0);
        end
        else if (roll < 81)
        begin
            // malformed literal: bad escape or missing close
            send_item(CH_APOS, 1'b0);
            if ($urandom_range(1))
                send_item(CH_BSLASH, 1'b0);
            else
                send_item(8'($urandom_range(255)), 1'b0);
            send_item(8'($urandom_range(255)), 1'b0);
        end
        else if (roll < 93)
        begin
            k = $urandom_range(1, 3);
            repeat (k) send_item(CH_SLASH, 1'b0);
        end
        else
            send_item(CH_STAR, 1'b0);
    endtask

    initial
    begin : stimulus
        int start_count;
        int ntok;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // doubled slash, stars before a comment close, newline inside a comment,
        // empty-looking literal, escape literal, string with backslash, held slash at end
        send_str("//*\n**/*\n");
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_str("'''");
        send_str("'\\n'");
        send_str("{[)");
        send_str("\"\\\"");
        send_str("/");
        send_end();
        // bad escape, then bytes ignored
        send_str("'\\qx");
        send_end();
        // text ends while the closing apostrophe is awaited
        send_str("'a");
        send_end();
        // text ends inside a comment
        send_str("/*");
        send_end();

        // deep nesting, parens going negative first: every depth comes back to zero
        calm = 1'b1;
        repeat (20)
        begin
            send_item(CH_LBRACE, 1'b0);
            send_item(CH_LBRACK, 1'b0);
            send_item(CH_RPAREN, 1'b0);
        end
        repeat (20)
        begin
            send_item(CH_RBRACE, 1'b0);
            send_item(CH_RBRACK, 1'b0);
            send_item(CH_LPAREN, 1'b0);
        end
        send_end();
        calm = 1'b0;

        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            if (items_sent - start_count >= CALM_FROM)
                calm = 1'b1;
            ntok = $urandom_range(1, 24);
            repeat (ntok) send_token();
            send_end();
        end
        s_tvalid <= 1'b0;
        calm = 1'b1;

        wait (results_due == 0);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

endmodule
